// File: hw/rtl/pfld_pkg.sv
// Shared types and constants for the page framebuffer line drawer.
// Holds the store geometry, operation codes and the beat structs.
// No dependencies; imported by every module of the block.
package pfld_pkg;

  // Store geometry
  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 64;
  localparam int PAGE_COUNT  = (MAX_HEIGHT + 7) / 8;
  localparam int STORE_DEPTH = MAX_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Operation codes
  localparam logic [1:0] OP_FILL  = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_LINE  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Register indexes on the configuration port
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Command beat
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] x_a;
    logic [7:0] y_a;
    logic [7:0] x_b;
    logic [7:0] y_b;
    logic       pixel_value;
    logic [7:0] fill_byte;
    logic [9:0] byte_index;
  } pfld_in_t;

  // Result beat
  typedef struct packed {
    logic [7:0] read_byte;
    logic       index_error;
  } pfld_out_t;

  // Status of the line stepper toward the store pipeline
  typedef struct packed {
    logic vld;   // a pixel coordinate is presented this cycle
    logic last;  // it is the end point of the line
  } pfld_step_t;

endpackage

// File: hw/rtl/pfld_line_step.sv
// Bresenham line stepper: walks from start to end, one pixel per cycle.
// Depends on pfld_pkg for the stepper status struct.
module pfld_line_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [7:0]          xs,
  input  logic [7:0]          ys,
  input  logic [7:0]          xe,
  input  logic [7:0]          ye,
  output logic [7:0]          px,
  output logic [7:0]          py,
  output pfld_pkg::pfld_step_t ctl
);
  import pfld_pkg::*;

  logic               busy_r, busy_nxt;
  logic [7:0]         x_r, x_nxt, y_r, y_nxt;
  logic [7:0]         xe_r, ye_r;
  logic [7:0]         dx_r, dy_r;
  logic               sx_r, sy_r;
  logic signed [11:0] err_r, err_nxt;

  logic [7:0]         dx_s, dy_s;
  logic signed [11:0] e2;
  logic               step_x, step_y, at_end;

  // Setup values from the command coordinates
  assign dx_s = (xe > xs) ? (xe - xs) : (xs - xe);
  assign dy_s = (ye > ys) ? (ye - ys) : (ys - ye);

  // One Bresenham decision per cycle
  assign e2     = err_r <<< 1;
  assign step_x = e2 > -$signed({4'b0, dy_r});
  assign step_y = e2 < $signed({4'b0, dx_r});
  assign at_end = (x_r == xe_r) && (y_r == ye_r);

  always_comb begin
    busy_nxt = busy_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    err_nxt  = err_r;
    if (start) begin
      busy_nxt = 1'b1;
      x_nxt    = xs;
      y_nxt    = ys;
      err_nxt  = $signed({4'b0, dx_s}) - $signed({4'b0, dy_s});
    end else if (busy_r) begin
      if (at_end) begin
        busy_nxt = 1'b0;
      end else begin
        if (step_x) x_nxt = sx_r ? (x_r + 8'd1) : (x_r - 8'd1);
        if (step_y) y_nxt = sy_r ? (y_r + 8'd1) : (y_r - 8'd1);
        err_nxt = err_r - (step_x ? $signed({4'b0, dy_r}) : 12'sd0)
                        + (step_y ? $signed({4'b0, dx_r}) : 12'sd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    err_r <= err_nxt;
    if (start) begin
      xe_r <= xe;
      ye_r <= ye;
      dx_r <= dx_s;
      dy_r <= dy_s;
      sx_r <= xs < xe;
      sy_r <= ys < ye;
    end
  end

  assign px       = x_r;
  assign py       = y_r;
  assign ctl.vld  = busy_r;
  assign ctl.last = busy_r && at_end;

endmodule

// File: hw/rtl/page_framebuffer_line_drawer_core.sv
// Top level of the page framebuffer line drawer: command FSM, frame store,
// pixel read-modify-write pipeline and APB register port.
// Depends on pfld_pkg and pfld_line_step.
//
//  port group | dir | beat / access
//  in_*       | in  | pfld_in_t command, valid/stall
//  out_*      | out | pfld_out_t result, valid/stall, one per command
//  cfg_*      | in  | APB registers: 0x0 active_width, 0x4 active_height
//
// A line draws one pixel per cycle through a one-port-read, one-port-write store
// with write forwarding; a fill writes one store byte per cycle.
// Reset clears control state, then a clearing pass zeroes the store; in_stall
// is high during it.
// A command is taken only while the engine is idle; a finished result sits in
// the output register, so the next command is taken while out_stall holds it.
module page_framebuffer_line_drawer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pfld_pkg::pfld_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pfld_pkg::pfld_out_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import pfld_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_FILL  = 7'b0000100,
    ST_DRAW  = 7'b0001000,
    ST_WB    = 7'b0010000,
    ST_READ  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t              state_r;
  logic [7:0]          width_r;
  logic [6:0]          height_r;

  logic [7:0]          mem [STORE_DEPTH];
  logic [7:0]          mem_rdata_r;
  logic [ADDR_W-1:0]   rd_addr;

  logic [ADDR_W-1:0]   fill_cnt_r;
  logic [7:0]          fill_val_r;

  logic                s1_vld_r;
  logic [ADDR_W-1:0]   s1_addr_r;
  logic [7:0]          s1_mask_r;
  logic                s1_on_r;
  logic                pix_on_r;

  logic                wr_vld_r;
  logic [ADDR_W-1:0]   wr_addr_r;
  logic [7:0]          wr_data_r;

  logic [7:0]          res_byte_r;
  logic                res_err_r;
  logic                out_valid_r;
  pfld_out_t           out_data_r;

  logic                in_acc, out_free, cfg_wr;
  logic [7:0]          eff_w;
  logic [6:0]          eff_h;
  logic [3:0]          pages;
  logic [11:0]         act_size;
  logic                bi_err;

  logic                step_start;
  logic [7:0]          step_x, step_y;
  pfld_step_t          step_ctl;
  logic                pix_in;
  logic [ADDR_W-1:0]   pix_addr;
  logic [7:0]          base_byte, rmw_byte;
  logic                sweep_end;

  // Handshakes
  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign in_stall = state_r != ST_IDLE;
  assign out_free = !out_valid_r || !out_stall;

  // Active geometry, saturated to the store size
  assign eff_w    = (width_r > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : width_r;
  assign eff_h    = (height_r > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : height_r;
  assign pages    = 4'(({1'b0, eff_h} + 8'd7) >> 3);
  assign act_size = 12'(eff_w) * 12'(pages);
  assign bi_err   = {2'b0, in_data.byte_index} >= act_size;

  // Line stepper; a single pixel is a line of one point
  assign step_start = in_acc && ((in_data.op == OP_PIXEL) || (in_data.op == OP_LINE));

  pfld_line_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .start (step_start),
    .xs    (in_data.x_a),
    .ys    (in_data.y_a),
    .xe    ((in_data.op == OP_LINE) ? in_data.x_b : in_data.x_a),
    .ye    ((in_data.op == OP_LINE) ? in_data.y_b : in_data.y_a),
    .px    (step_x),
    .py    (step_y),
    .ctl   (step_ctl)
  );

  // Clip and address of the stepped pixel
  assign pix_in   = step_ctl.vld && (step_x < eff_w) && (step_y < {1'b0, eff_h});
  assign pix_addr = ADDR_W'(13'(step_y[7:3]) * 13'(eff_w) + 13'(step_x));
  assign rd_addr  = (state_r == ST_IDLE) ? in_data.byte_index[ADDR_W-1:0] : pix_addr;

  // Modify stage, forwarding the byte written in the previous cycle
  assign base_byte = (wr_vld_r && (wr_addr_r == s1_addr_r)) ? wr_data_r : mem_rdata_r;
  assign rmw_byte  = s1_on_r ? (base_byte | s1_mask_r) : (base_byte & ~s1_mask_r);

  assign sweep_end = fill_cnt_r == ADDR_W'(STORE_DEPTH - 1);

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if ((state_r == ST_CLEAR) || (state_r == ST_FILL)) begin
      mem[fill_cnt_r] <= (state_r == ST_CLEAR) ? 8'h00 : fill_val_r;
    end else if (s1_vld_r) begin
      mem[s1_addr_r] <= rmw_byte;
    end
    mem_rdata_r <= mem[rd_addr];
  end

  // Pixel pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      wr_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= pix_in;
      wr_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= pix_addr;
    s1_mask_r <= 8'd1 << step_y[2:0];
    s1_on_r   <= pix_on_r;
    wr_addr_r <= s1_addr_r;
    wr_data_r <= rmw_byte;
  end

  // Command sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      fill_cnt_r <= '0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          fill_cnt_r <= sweep_end ? '0 : fill_cnt_r + 1'b1;
          if (sweep_end) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_acc) begin
            case (in_data.op)
              OP_FILL:  state_r <= ST_FILL;
              OP_PIXEL: state_r <= ST_DRAW;
              OP_LINE:  state_r <= ST_DRAW;
              default:  state_r <= ST_READ;
            endcase
          end
        end
        ST_FILL: begin
          fill_cnt_r <= sweep_end ? '0 : fill_cnt_r + 1'b1;
          if (sweep_end) state_r <= ST_DONE;
        end
        ST_DRAW: begin
          if (step_ctl.last) state_r <= ST_WB;
        end
        ST_WB:   state_r <= ST_DONE;
        ST_READ: state_r <= ST_DONE;
        ST_DONE: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Command payload and pending result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      fill_val_r <= in_data.fill_byte;
      pix_on_r   <= (in_data.op == OP_LINE) || in_data.pixel_value;
      res_byte_r <= 8'h00;
      res_err_r  <= (in_data.op == OP_READ) && bi_err;
    end else if (state_r == ST_READ) begin
      res_byte_r <= res_err_r ? 8'h00 : mem_rdata_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_data_r.read_byte   <= res_byte_r;
      out_data_r.index_error <= res_err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Register port
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_HEIGHT) ? {25'b0, height_r} : {24'b0, width_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 8'(MAX_WIDTH);
      height_r <= 7'(MAX_HEIGHT);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_WIDTH) width_r <= cfg_pwdata[7:0];
      else                           height_r <= cfg_pwdata[6:0];
    end
  end

`ifndef SYNTH
  // The clearing pass runs once, right after reset
  a_no_reclear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR) |=> (state_r != ST_CLEAR))
    else $error("store clearing pass re-entered");

  // A result appears only out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside done state");

  // An index error carries a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.index_error) |-> (out_data_r.read_byte == 8'h00))
    else $error("index error with nonzero byte");

  // A fill sweep starts at the first store byte
  a_fill_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_FILL) |-> (fill_cnt_r == '0))
    else $error("fill sweep not starting at zero");

  // Pixel writes happen only while drawing or flushing the last pixel
  a_rmw_window: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> ((state_r == ST_DRAW) || (state_r == ST_WB)))
    else $error("pixel write outside draw");
`endif

endmodule
